// File: rtl/core/bobq_pkg.sv
// Shared types, constants and helper functions for the branch outcome bit queue.
`timescale 1ns / 1ps

package bobq_pkg;

	// Default ring depth in outcome bits; a power of two of at least one row.
	localparam int DEPTH_DEFAULT = 4096;

	// Header offsets of the two packet sizes.
	localparam int SHORT_HEADER_BITS = 1;
	localparam int LONG_HEADER_BITS = 16;

	// Field widths of the two streams.
	localparam int MODE_W = 2;
	localparam int PACKET_W = 64;
	localparam int SHORT_PACKET_W = 8;
	localparam int OUTCOME_W = 2;
	localparam int COUNT_OUT_W = 13;
	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 16;

	// The store is kept in rows of 64 outcome bits.
	localparam int ROW_W = 64;
	localparam int ROW_OFS_W = 6;
	localparam int POS_W = 6;
	localparam int LEN_W = 6;

	// Item kinds carried in the mode field.
	typedef enum logic [MODE_W-1:0] {
		MODE_POP        = 2'd0,
		MODE_PUSH_SHORT = 2'd1,
		MODE_PUSH_LONG  = 2'd2,
		MODE_FLUSH      = 2'd3
	} mode_t;

	// Outcome codes.
	localparam logic [OUTCOME_W-1:0] OUTCOME_NOT_TAKEN = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_TAKEN = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_NONE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic align;
		logic write_lo;
		logic write_hi;
		logic pop_rd;
		logic pop_take;
		logic flush;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_pop;
		logic is_flush;
		logic empty;
		logic push_ok;
		logic spans;
		logic out_free;
	} dp_status_t;

	// Position of the highest set bit; the top bit of the result says one was found.
	function automatic logic [POS_W:0] stop_bit(input logic [PACKET_W-1:0] v);
		logic [POS_W:0] res;
		res = '0;
		for (int k = 0; k < PACKET_W; k++) begin
			if (v[k]) begin
				res = {1'b1, POS_W'(k)};
			end
		end
		return res;
	endfunction

	// Mirror a 64-bit word end for end.
	function automatic logic [PACKET_W-1:0] bit_reverse(input logic [PACKET_W-1:0] v);
		logic [PACKET_W-1:0] res;
		res = '0;
		for (int k = 0; k < PACKET_W; k++) begin
			res[k] = v[PACKET_W-1-k];
		end
		return res;
	endfunction

endpackage

// File: rtl/core/bobq_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
`timescale 1ns / 1ps

module bobq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  bobq_pkg::dp_status_t   sts,
	output bobq_pkg::dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_ALIGN,
		S_WRITE_LO,
		S_WRITE_HI,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (sts.is_flush) begin
					cmd.flush = 1'b1;
					state_d = S_DONE;
				end else if (sts.is_pop) begin
					if (sts.empty) begin
						state_d = S_DONE;
					end else begin
						cmd.pop_rd = 1'b1;
						state_d = S_READ;
					end
				end else begin
					cmd.scan = 1'b1;
					state_d = S_ALIGN;
				end
			end
			S_READ: begin
				cmd.pop_take = 1'b1;
				state_d = S_DONE;
			end
			S_ALIGN: begin
				cmd.align = 1'b1;
				state_d = S_WRITE_LO;
			end
			S_WRITE_LO: begin
				if (sts.push_ok) begin
					cmd.write_lo = 1'b1;
					state_d = sts.spans ? S_WRITE_HI : S_DONE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_WRITE_HI: begin
				cmd.write_hi = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/bobq_dp.sv
// Datapath: bit store, ring pointers, stop-bit scan, alignment and result register.
`timescale 1ns / 1ps

module bobq_dp #(
	parameter int DEPTH = bobq_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [bobq_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bobq_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  bobq_pkg::dp_cmd_t                   cmd,
	output bobq_pkg::dp_status_t                sts
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int ROWS = DEPTH / bobq_pkg::ROW_W;
	localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RW = bobq_pkg::ROW_W;

	// Transaction registers.
	bobq_pkg::mode_t                    mode_q;
	logic [bobq_pkg::PACKET_W-1:0]      packet_q;
	logic [bobq_pkg::POS_W-1:0]         stop_q;
	logic                               found_q;
	logic [RW-1:0]                      payload_q;
	logic [bobq_pkg::LEN_W-1:0]         len_q;
	logic                               push_ok_q;
	logic                               ovf_q;
	logic [RW-1:0]                      hi_data_q;
	logic [RW-1:0]                      hi_mask_q;
	logic [RAW-1:0]                     hi_row_q;
	logic [RW-1:0]                      rd_row_q;
	logic [bobq_pkg::OUTCOME_W-1:0]     outcome_q;

	// Queue state.
	logic [AW-1:0]                      rp_q;
	logic [AW-1:0]                      wp_q;
	logic [CW-1:0]                      count_q;

	// Result register.
	logic                               out_valid_q;
	logic [bobq_pkg::OUT_DATA_W-1:0]    out_data_q;

	// Bit store in rows of 64 outcomes.
	logic [RW-1:0]                      outcome_mem [ROWS];

	// Combinational helpers.
	bobq_pkg::mode_t                    in_mode;
	logic [bobq_pkg::POS_W:0]           stop_res;
	logic [bobq_pkg::POS_W-1:0]         header;
	logic                               has_payload;
	logic [bobq_pkg::LEN_W-1:0]         len;
	logic                               too_full;
	logic [bobq_pkg::POS_W-1:0]         align_shift;
	logic [RW-1:0]                      len_mask;
	logic [2*RW-1:0]                    wide_data;
	logic [2*RW-1:0]                    wide_mask;
	logic [RAW-1:0]                     wr_row;
	logic [RAW-1:0]                     rd_row;
	logic [RAW-1:0]                     next_row;

	assign in_mode = bobq_pkg::mode_t'(s_tdata[bobq_pkg::MODE_W-1:0]);

	// Scan and payload length for the current push.
	assign stop_res = bobq_pkg::stop_bit(packet_q);
	assign header = (mode_q == bobq_pkg::MODE_PUSH_LONG) ?
		bobq_pkg::POS_W'(bobq_pkg::LONG_HEADER_BITS) :
		bobq_pkg::POS_W'(bobq_pkg::SHORT_HEADER_BITS);
	assign has_payload = found_q && (stop_q > header);
	assign len = stop_q - header;
	assign too_full = ((CW+1)'(count_q) + (CW+1)'(len)) > (CW+1)'(DEPTH);

	// The bit just below the stop bit lands at position zero of the payload.
	assign align_shift = bobq_pkg::POS_W'(bobq_pkg::PACKET_W - 1) - stop_q;

	// Place the payload at the write offset across two rows.
	assign len_mask = (RW'(1) << len_q) - RW'(1);
	assign wide_data = {{RW{1'b0}}, payload_q & len_mask} << wp_q[bobq_pkg::ROW_OFS_W-1:0];
	assign wide_mask = {{RW{1'b0}}, len_mask} << wp_q[bobq_pkg::ROW_OFS_W-1:0];
	assign wr_row = RAW'(wp_q >> bobq_pkg::ROW_OFS_W);
	assign rd_row = RAW'(rp_q >> bobq_pkg::ROW_OFS_W);
	assign next_row = (ROWS > 1) ? RAW'(wr_row + 1'b1) : '0;

	// Status toward the controller.
	assign sts.is_pop = (mode_q == bobq_pkg::MODE_POP);
	assign sts.is_flush = (mode_q == bobq_pkg::MODE_FLUSH);
	assign sts.empty = (count_q == '0);
	assign sts.push_ok = push_ok_q;
	assign sts.spans = |wide_mask[2*RW-1:RW];
	assign sts.out_free = !out_valid_q || m_tready;

	// Per-transaction registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			if (in_mode == bobq_pkg::MODE_PUSH_SHORT) begin
				packet_q <= {{(bobq_pkg::PACKET_W-bobq_pkg::SHORT_PACKET_W){1'b0}},
					s_tdata[bobq_pkg::MODE_W +: bobq_pkg::SHORT_PACKET_W]};
			end else begin
				packet_q <= s_tdata[bobq_pkg::MODE_W +: bobq_pkg::PACKET_W];
			end
			outcome_q <= bobq_pkg::OUTCOME_NONE;
			ovf_q <= 1'b0;
			push_ok_q <= 1'b0;
		end
		if (cmd.scan) begin
			found_q <= stop_res[bobq_pkg::POS_W];
			stop_q <= stop_res[bobq_pkg::POS_W-1:0];
		end
		if (cmd.align) begin
			payload_q <= (bobq_pkg::bit_reverse(packet_q) >> 1) >> align_shift;
			len_q <= len;
			push_ok_q <= has_payload && !too_full;
			ovf_q <= has_payload && too_full;
		end
		if (cmd.write_lo) begin
			hi_data_q <= wide_data[2*RW-1:RW];
			hi_mask_q <= wide_mask[2*RW-1:RW];
			hi_row_q <= next_row;
		end
		if (cmd.pop_rd) begin
			rd_row_q <= outcome_mem[rd_row];
		end
		if (cmd.pop_take) begin
			outcome_q <= {1'b0, rd_row_q[rp_q[bobq_pkg::ROW_OFS_W-1:0]]};
		end
	end

	// Bit store writes with per-bit enables, one row a cycle.
	always_ff @(posedge clk) begin
		if (cmd.write_lo) begin
			for (int b = 0; b < RW; b++) begin
				if (wide_mask[b]) begin
					outcome_mem[wr_row][b] <= wide_data[b];
				end
			end
		end else if (cmd.write_hi) begin
			for (int b = 0; b < RW; b++) begin
				if (hi_mask_q[b]) begin
					outcome_mem[hi_row_q][b] <= hi_data_q[b];
				end
			end
		end
	end

	// Ring pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
			count_q <= '0;
		end else begin
			priority if (cmd.flush) begin
				rp_q <= '0;
				wp_q <= '0;
				count_q <= '0;
			end else if (cmd.write_lo) begin
				wp_q <= wp_q + AW'(len_q);
				count_q <= count_q + CW'(len_q);
			end else if (cmd.pop_take) begin
				rp_q <= rp_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Result register; it frees as soon as the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= {ovf_q, bobq_pkg::COUNT_OUT_W'(count_q), outcome_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// The fill count never exceeds the ring.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	// Pointer distance agrees with the fill count.
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		AW'(wp_q - rp_q) == AW'(count_q))
		else $error("pointers disagree with fill count");

	// A second-row write only follows a first-row write.
	a_hi_after_lo: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_hi |-> $past(cmd.write_lo))
		else $error("second row written without first");

	// A flush empties the queue.
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (count_q == '0) && (rp_q == '0) && (wp_q == '0))
		else $error("flush left queue state");

	// A dropped push never writes the store.
	a_ovf_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> !cmd.write_lo && !cmd.write_hi)
		else $error("dropped push wrote the store");

endmodule

// File: rtl/core/branch_outcome_bit_queue.sv
// Top level of the branch outcome bit queue: controller plus datapath.
//
// Usage: the slave stream carries one transaction per item: mode in s_tdata[1:0]
// (pop, short push, long push, flush) and the raw trace packet in s_tdata[65:2].
// Every accepted transaction yields exactly one result transaction on the master
// stream: outcome in m_tdata[1:0], pending count in m_tdata[14:2], overflow flag
// in m_tdata[15].
// Steps per transaction, from acceptance in the idle state: the scan state decodes
// the kind; a flush or an empty pop goes straight to the done state, a pop reads
// its 64-bit row of the bit store and takes the bit, and a push scans, aligns and,
// if its payload fits, writes the first row, then a second row when the payload
// crosses a 64-bit row of the bit store, since the store has one write port. The
// done state loads the result into the output register. A new transaction is taken
// in the cycle after the previous result is loaded, while that result may still
// wait in the output register. If the receiver stalls, the finished result holds
// in the output register and the next transaction stops before its result, holding
// s_tready low after it. Reset clears the pointers, the fill count, the controller
// and the output valid flag at once; the bit store keeps no reset and needs no
// clearing pass. DEPTH must be a power of two of at least 64.
`timescale 1ns / 1ps

module branch_outcome_bit_queue #(
	parameter int DEPTH = bobq_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0: mode[1:0], packet[65:2], zero fill [71:66].
	input  logic [bobq_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// Fields from bit 0: outcome[1:0], pending_count[14:2], overflow[15].
	output logic [bobq_pkg::OUT_DATA_W-1:0]     m_tdata
);

	bobq_pkg::dp_cmd_t      cmd;
	bobq_pkg::dp_status_t   sts;

	// Sequencer.
	bobq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Store, pointers and result register.
	bobq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the branch outcome bit queue with a shadow model of the ring.
`timescale 1ns / 1ps

module tb_top;

	import bobq_pkg::*;

	localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
	localparam int FILL_W = IN_DATA_W - MODE_W - PACKET_W;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 32;
	localparam int PRINT_CAP = 40;
	localparam int RANDOM_ITEMS = 1900;

	// One result transaction as the block reports it.
	typedef struct packed {
		logic [OUTCOME_W-1:0]   outcome;
		logic [COUNT_OUT_W-1:0] pending;
		logic                   overflow;
	} queue_reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Shadow copy of the queued outcomes, oldest first, and the replies still due.
	bit           shadow_outcomes[$];
	queue_reply_t reply_fifo[$];

	int mismatch_count = 0;
	int replies_seen = 0;
	int cycle_count = 0;
	int burst_left = 1;

	branch_outcome_bit_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Free-running clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog that ends a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Position of the highest set bit, or -1 when the word is zero.
	function automatic int stop_position(input logic [PACKET_W-1:0] v);
		int pos;
		pos = -1;
		for (int k = PACKET_W - 1; k >= 0 && pos < 0; k--) begin
			if (v[k]) begin
				pos = k;
			end
		end
		return pos;
	endfunction

	// Queue the payload below the stop bit, highest bit first; returns the drop flag.
	function automatic logic queue_payload(input logic [PACKET_W-1:0] v, input int header);
		int s;
		s = stop_position(v);
		if (s <= header) begin
			return 1'b0;
		end
		if (shadow_outcomes.size() + (s - header) > QUEUE_DEPTH) begin
			return 1'b1;
		end
		for (int j = s - 1; j >= header; j--) begin
			shadow_outcomes.push_back(v[j]);
		end
		return 1'b0;
	endfunction

	// Apply one accepted transaction to the shadow queue and return the reply it causes.
	function automatic queue_reply_t step_outcome_queue(input mode_t mode,
			input logic [PACKET_W-1:0] packet);
		queue_reply_t r;
		r.outcome = OUTCOME_NONE;
		r.overflow = 1'b0;
		case (mode)
			MODE_POP: begin
				if (shadow_outcomes.size() != 0) begin
					r.outcome = shadow_outcomes.pop_front() ? OUTCOME_TAKEN : OUTCOME_NOT_TAKEN;
				end
			end
			MODE_PUSH_SHORT: begin
				r.overflow = queue_payload({{(PACKET_W-SHORT_PACKET_W){1'b0}},
					packet[SHORT_PACKET_W-1:0]}, SHORT_HEADER_BITS);
			end
			MODE_PUSH_LONG: begin
				r.overflow = queue_payload(packet, LONG_HEADER_BITS);
			end
			default: begin
				shadow_outcomes.delete();
			end
		endcase
		r.pending = COUNT_OUT_W'(shadow_outcomes.size());
		return r;
	endfunction

	// Print one line per mismatch, up to a cap, and count every one.
	task automatic note_mismatch(input string field, input int got, input int want);
		if (mismatch_count < PRINT_CAP) begin
			$display("mismatch in reply %0d, %0s: got %0d, expected %0d",
				replies_seen, field, got, want);
		end
		mismatch_count++;
	endtask

	// Send one transaction, record its reply, and idle between bursts.
	task automatic send_item(input mode_t mode, input logic [PACKET_W-1:0] packet);
		int gap;
		s_tdata <= {{FILL_W{1'b0}}, packet, mode};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		reply_fifo.push_back(step_outcome_queue(mode, packet));
		burst_left--;
		if (burst_left <= 0) begin
			// Some bursts run long with no gaps at all.
			if ($urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(100, 300);
			end else begin
				burst_left = $urandom_range(1, 12);
			end
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Random packet shaped for the given kind, with noise where the block ignores bits.
	function automatic logic [PACKET_W-1:0] random_packet(input mode_t mode);
		logic [PACKET_W-1:0] noise;
		logic [PACKET_W-1:0] stop;
		int s;
		noise = {$urandom, $urandom};
		if ($urandom_range(0, 7) == 0 || mode == MODE_POP || mode == MODE_FLUSH) begin
			return noise;
		end
		if ($urandom_range(0, 31) == 0) begin
			return '0;
		end
		if (mode == MODE_PUSH_SHORT) begin
			s = $urandom_range(0, SHORT_PACKET_W - 1);
			stop = 64'd1 << s;
			return (noise & (stop - 64'd1)) | stop |
				($urandom_range(0, 1) ? (noise & ~64'hFF) : 64'd0);
		end
		s = $urandom_range(0, PACKET_W - 1);
		stop = 64'd1 << s;
		return (noise & (stop - 64'd1)) | stop;
	endfunction

	// Edge packets of both sizes, header corner cases, pops and flushes.
	task automatic test_edge_packets();
		send_item(MODE_POP, 64'd0);
		send_item(MODE_FLUSH, 64'd0);
		send_item(MODE_PUSH_SHORT, 64'd0);
		send_item(MODE_PUSH_SHORT, 64'h01);
		send_item(MODE_PUSH_SHORT, 64'h02);
		send_item(MODE_PUSH_SHORT, 64'hFFFF_FFFF_FFFF_FF00);
		send_item(MODE_PUSH_SHORT, 64'h03);
		send_item(MODE_PUSH_SHORT, 64'hFF);
		send_item(MODE_PUSH_SHORT, 64'h0123_4567_89AB_CD80);
		send_item(MODE_PUSH_LONG, 64'd0);
		send_item(MODE_PUSH_LONG, 64'h0000_0000_0001_FFFF);
		send_item(MODE_PUSH_LONG, 64'h0000_0000_0000_FFFF);
		send_item(MODE_PUSH_LONG, 64'h0000_0000_0003_0000);
		send_item(MODE_PUSH_LONG, 64'h0000_0000_0002_FFFF);
		send_item(MODE_PUSH_LONG, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(MODE_PUSH_LONG, 64'h8000_0000_0000_0000);
		send_item(MODE_PUSH_LONG, 64'h5555_5555_5555_5555);
		repeat (4) send_item(MODE_POP, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(MODE_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(MODE_POP, 64'd0);
		send_item(MODE_PUSH_SHORT, 64'h5A);
		send_item(MODE_POP, 64'd0);
	endtask

	// Fill the ring to exactly its depth, try pushes on the full ring, pop three outcomes, refill it and flush.
	task automatic test_fill_to_capacity();
		int room;
		logic [PACKET_W-1:0] stop;
		send_item(MODE_FLUSH, 64'd0);
		while (shadow_outcomes.size() + (PACKET_W - 1 - LONG_HEADER_BITS) <= QUEUE_DEPTH) begin
			send_item(MODE_PUSH_LONG, {$urandom, $urandom} | 64'h8000_0000_0000_0000);
		end
		// Top up with short packets whose payload just fits.
		while (shadow_outcomes.size() < QUEUE_DEPTH) begin
			room = QUEUE_DEPTH - shadow_outcomes.size();
			if (room > SHORT_PACKET_W - 1 - SHORT_HEADER_BITS) begin
				room = SHORT_PACKET_W - 1 - SHORT_HEADER_BITS;
			end
			stop = 64'd1 << (room + SHORT_HEADER_BITS);
			send_item(MODE_PUSH_SHORT, (64'($urandom) & (stop - 64'd1)) | stop);
		end
		send_item(MODE_PUSH_SHORT, 64'h04);
		send_item(MODE_PUSH_LONG, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(MODE_PUSH_SHORT, 64'h01);
		send_item(MODE_PUSH_LONG, 64'h0000_0000_0001_0000);
		repeat (3) send_item(MODE_POP, 64'd0);
		send_item(MODE_PUSH_LONG, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(MODE_PUSH_SHORT, 64'h0D);
		send_item(MODE_PUSH_SHORT, 64'h06);
		send_item(MODE_FLUSH, 64'd0);
		send_item(MODE_POP, 64'd0);
	endtask

	// Random traffic in stretches that are each fill-heavy or drain-heavy at random.
	task automatic test_random_traffic(input int n_items);
		int stretch_left;
		int pick;
		bit filling;
		mode_t mode;
		stretch_left = 0;
		filling = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if (stretch_left == 0) begin
				filling = 1'($urandom_range(0, 1));
				stretch_left = $urandom_range(50, 250);
			end
			stretch_left--;
			pick = $urandom_range(0, 99);
			if (filling) begin
				mode = pick < 25 ? MODE_POP : pick < 55 ? MODE_PUSH_SHORT :
					pick < 98 ? MODE_PUSH_LONG : MODE_FLUSH;
			end else begin
				mode = pick < 96 ? MODE_POP : pick < 98 ? MODE_PUSH_SHORT :
					pick < 99 ? MODE_PUSH_LONG : MODE_FLUSH;
			end
			send_item(mode, random_packet(mode));
		end
	endtask

	// Receiver backpressure: styles picked anew every stretch, one of them always ready.
	int ready_style = 0;
	int style_left = 0;
	int style_tick = 0;
	always @(posedge clk) begin
		if (style_left == 0) begin
			ready_style = $urandom_range(0, 3);
			style_left = $urandom_range(16, 200);
			style_tick = 0;
		end
		style_left--;
		style_tick++;
		case (ready_style)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (style_tick % 5 == 0);
			default: m_tready <= (style_tick % 24 == 23);
		endcase
	end

	// Compare each result transaction with the oldest reply still due.
	queue_reply_t want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (reply_fifo.size() == 0) begin
				note_mismatch("reply with none due", int'(m_tdata), -1);
			end else begin
				want = reply_fifo.pop_front();
				if (m_tdata[1:0] !== want.outcome) begin
					note_mismatch("outcome", int'(m_tdata[1:0]), int'(want.outcome));
				end
				if (m_tdata[14:2] !== want.pending) begin
					note_mismatch("pending_count", int'(m_tdata[14:2]), int'(want.pending));
				end
				if (m_tdata[15] !== want.overflow) begin
					note_mismatch("overflow", int'(m_tdata[15]), int'(want.overflow));
				end
			end
			replies_seen++;
		end
	end

	// Reset, run the tests in turn, drain and report.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_packets();
		test_fill_to_capacity();
		test_random_traffic(RANDOM_ITEMS);
		s_tvalid <= 1'b0;
		while (reply_fifo.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && reply_fifo.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
